// File: sv/signed_prefix_varint_encoder_core_macros.svh
// Assertion helpers used by the encoder back end.
`ifndef SIGNED_PREFIX_VARINT_ENCODER_CORE_MACROS_SVH
`define SIGNED_PREFIX_VARINT_ENCODER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SPVE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("spve check failed");

// Check that a condition implies another in the next cycle.
`define SPVE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("spve check failed");

`endif

// File: sv/spve_pkg.sv
package spve_pkg;

  localparam int unsigned ValueW = 64;

  // Byte count of the escape form: marker byte plus eight raw bytes.
  localparam logic [3:0] EscBytes = 4'd9;
  localparam logic [7:0] EscByte  = 8'hFF;

  // One classified request: the value and the byte count of its code.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [3:0]        nbytes;
  } item_t;

  // Build the top byte of a code of nbytes bytes (1 to 8).
  function automatic logic [7:0] top_byte(input logic [3:0] nbytes, input logic [7:0] raw);
    logic [7:0] prefix;
    logic [7:0] mask;
    prefix = 8'hFF << (4'd9 - nbytes);
    mask   = 8'hFF >> nbytes;
    return prefix | (raw & mask);
  endfunction

endpackage

// File: sv/signed_prefix_varint_encoder_core.sv
// Signed prefix-length varint encoder. Push one signed 64-bit value; pop its
// code one byte per cycle while pop is high, most significant byte first, with
// last_byte_o set on the final byte. A value that fits in 7L signed bits (L = 1
// to 8) gives L bytes; anything wider gives 0xFF followed by the eight raw bytes.
// Values are classified on entry and queued (QueueDepth entries), so pushes are
// taken every cycle until the queue fills. The byte-wide serializer sets the
// rate: a value holds the result port until all of its 1 to 9 bytes are popped,
// and with the queue empty its first byte is available the cycle after the push.
module signed_prefix_varint_encoder_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [63:0] value_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         code_byte_o,
  output logic               last_byte_o
);
  import spve_pkg::*;

  item_t in_item;
  item_t head_item;
  logic  done;

  spve_front u_front (
    .value_i (value_i),
    .item_o  (in_item)
  );

  spve_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item),
    .pop_i   (done),
    .rdata_o (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  spve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .valid_i     (!empty),
    .pop_i       (pop),
    .code_byte_o (code_byte_o),
    .last_byte_o (last_byte_o),
    .done_o      (done)
  );

endmodule

// File: sv/spve_front.sv
module spve_front (
  input  logic signed [63:0] value_i,
  output spve_pkg::item_t    item_o
);
  import spve_pkg::*;

  logic [3:0] nbytes;

  // Find the shortest length whose 7L-bit signed range holds the value.
  always_comb begin
    logic signed [ValueW-1:0] hi;
    nbytes = EscBytes;
    for (int l = 8; l >= 1; l--) begin
      hi = value_i >>> (7 * l - 1);
      if ((hi == '0) || (hi == '1)) begin
        nbytes = 4'(l);
      end
    end
  end

  assign item_o.value  = value_i;
  assign item_o.nbytes = nbytes;

endmodule

// File: sv/spve_fifo.sv
module spve_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spve_pkg::item_t wdata_i,
  input  logic            pop_i,
  output spve_pkg::item_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import spve_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed request.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/spve_back.sv
`include "signed_prefix_varint_encoder_core_macros.svh"

module spve_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spve_pkg::item_t item_i,
  input  logic            valid_i,
  input  logic            pop_i,
  output logic [7:0]      code_byte_o,
  output logic            last_byte_o,
  output logic            done_o
);
  import spve_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic [3:0] sel_full;
  logic [2:0] sel;
  logic [7:0] raw;
  logic       take;

  // Pick the value byte that this position carries, counted from the low end.
  assign sel_full = item_i.nbytes - 4'd1 - idx_q;
  assign sel      = sel_full[2:0];
  assign raw      = item_i.value[{sel, 3'b000} +: 8];

  // Form the byte: prefix on the first one, raw bytes after.
  always_comb begin
    if (idx_q == '0) begin
      code_byte_o = (item_i.nbytes == EscBytes) ? EscByte : top_byte(item_i.nbytes, raw);
    end else begin
      code_byte_o = raw;
    end
  end

  assign last_byte_o = (sel_full == '0);
  assign take        = pop_i && valid_i;
  assign done_o      = take && last_byte_o;

  // Step through the bytes; restart at the next request.
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_byte_o ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `SPVE_ASSERT_SAME(a_nbytes_range, clk_i, rst_ni, valid_i,
    (item_i.nbytes != 4'd0) && (item_i.nbytes <= EscBytes))
  `SPVE_ASSERT_SAME(a_idx_in_code, clk_i, rst_ni, valid_i, idx_q < item_i.nbytes)
  `SPVE_ASSERT_NEXT(a_restart, clk_i, rst_ni, done_o, idx_q == 4'd0)
  `SPVE_ASSERT_NEXT(a_hold_mid_code, clk_i, rst_ni, take && !last_byte_o,
    $stable(item_i) && valid_i)

endmodule

// File: tb/sv/signed_prefix_varint_encoder_core_tb.sv
`timescale 1ns / 100ps

module signed_prefix_varint_encoder_core_tb;
  import spve_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPerPhase = 49;
  localparam int unsigned MaxReported = 10;

  // One code byte as it should leave the encoder.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_byte_t;

  // Directed stimulus row; nbytes of zero means the code comes from the predictor.
  typedef struct packed {
    logic signed [63:0] value;
    logic [3:0]         nbytes;
    logic [71:0]        code;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [63:0] value_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         code_byte_o;
  logic               last_byte_o;

  code_byte_t  code_bytes_due [$];
  code_byte_t  head_byte;
  stim_row_t   stim_table [0:24];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned values_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned codes_by_len [1:9];

  signed_prefix_varint_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .empty       (empty),
    .pop         (pop),
    .code_byte_o (code_byte_o),
    .last_byte_o (last_byte_o)
  );

  always #1 clk_i = ~clk_i;

  // Append the code of one value to the bytes still due.
  function automatic void predict_code(input logic signed [63:0] v);
    logic signed [63:0] lim;
    int unsigned        len;
    logic [7:0]         prefix;
    logic [7:0]         mask;
    len = 0;
    for (int l = 1; l <= 8; l++) begin
      lim = 64'sd1 <<< (7 * l - 1);
      if (len == 0 && v >= -lim && v < lim) len = l;
    end
    if (len == 0) begin
      code_bytes_due.push_back('{EscByte, 1'b0});
      for (int k = 0; k < 8; k++)
        code_bytes_due.push_back('{v[63 - 8 * k -: 8], k == 7});
    end else begin
      prefix = 8'hFE << (8 - len);
      mask   = ~(8'hFF << (8 - len));
      code_bytes_due.push_back('{prefix | (v[8 * (len - 1) +: 8] & mask), len == 1});
      for (int k = 1; k < len; k++)
        code_bytes_due.push_back('{v[8 * (len - 1 - k) +: 8], k == len - 1});
    end
  endfunction

  // Count and, for the first few, report a bad or unexpected byte.
  task automatic flag_mismatch(input string what, input code_byte_t want);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $time, what, want.code, want.last, code_byte_o, last_byte_o);
  endtask

  // Offer one request after a random gap; record its code once it is taken.
  task automatic send_value(input logic signed [63:0] v, input logic [3:0] nbytes,
                            input logic [71:0] code);
    int unsigned due_before;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    due_before = code_bytes_due.size();
    if (nbytes == 0) begin
      predict_code(v);
    end else begin
      for (int k = 0; k < nbytes; k++)
        code_bytes_due.push_back('{code[8 * (nbytes - 1 - k) +: 8], k == nbytes - 1});
    end
    codes_by_len[code_bytes_due.size() - due_before]++;
    values_sent++;
  endtask

  // Hold off the sender until every byte due has been popped.
  task automatic drain_codes();
    push <= 1'b0;
    while (code_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // Drive the receiver side: pop, stalling at the current rate.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Check each popped byte against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (code_bytes_due.size() == 0) begin
        flag_mismatch("unexpected byte", '0);
      end else begin
        head_byte = code_bytes_due.pop_front();
        if (code_byte_o !== head_byte.code || last_byte_o !== head_byte.last)
          flag_mismatch("code mismatch", head_byte);
        bytes_checked++;
      end
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no request or byte moved for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0]        raw;
    logic signed [63:0] lim;
    logic signed [63:0] v;
    int unsigned        cls;
    int unsigned        w;

    for (int i = 1; i <= 9; i++) codes_by_len[i] = 0;

    // Length boundaries, sign extremes and the escape form.
    stim_table = '{
      '{64'sd0, 4'd1, 72'h00},
      '{-64'sd1, 4'd1, 72'h7F},
      '{64'sd1, 4'd0, 72'h0},
      '{64'sd63, 4'd1, 72'h3F},
      '{-64'sd64, 4'd1, 72'h40},
      '{64'sd64, 4'd2, 72'h8040},
      '{-64'sd65, 4'd2, 72'hBFBF},
      '{64'sd8191, 4'd2, 72'h9FFF},
      '{-64'sd8192, 4'd2, 72'hA000},
      '{64'sd8192, 4'd0, 72'h0},
      '{-64'sd8193, 4'd0, 72'h0},
      '{64'sd1048575, 4'd0, 72'h0},
      '{-64'sd1048576, 4'd0, 72'h0},
      '{64'sd134217728, 4'd0, 72'h0},
      '{-64'sd134217729, 4'd0, 72'h0},
      '{64'sd17179869183, 4'd0, 72'h0},
      '{-64'sd2199023255552, 4'd0, 72'h0},
      '{64'sd281474976710656, 4'd0, 72'h0},
      '{-64'sd281474976710657, 4'd0, 72'h0},
      '{64'sh007F_FFFF_FFFF_FFFF, 4'd8, 72'hFE7F_FFFF_FFFF_FFFF},
      '{64'shFF80_0000_0000_0000, 4'd8, 72'hFE80_0000_0000_0000},
      '{64'sh0080_0000_0000_0000, 4'd9, 72'hFF_0080_0000_0000_0000},
      '{64'shFF7F_FFFF_FFFF_FFFF, 4'd9, 72'hFF_FF7F_FFFF_FFFF_FFFF},
      '{64'sh8000_0000_0000_0000, 4'd9, 72'hFF_8000_0000_0000_0000},
      '{64'sh7FFF_FFFF_FFFF_FFFF, 4'd9, 72'hFF_7FFF_FFFF_FFFF_FFFF}
    };

    // Hold reset low at the start, then release it on an edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table back to back.
    for (int i = 0; i < 25; i++)
      send_value(stim_table[i].value, stim_table[i].nbytes, stim_table[i].code);
    drain_codes();

    // Random values in four idling phases: none, sender, receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = (phase == 1) ? 83 : (phase == 3) ? 11 : 0;
      rx_stall_pct = (phase == 2) ? 83 : (phase == 3) ? 11 : 0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        raw = {$urandom, $urandom};
        cls = $urandom_range(9);
        if (cls >= 8) begin
          // Full width: mostly escape codes.
          v = raw;
        end else begin
          w   = 7 * (cls + 1);
          lim = 64'sd1 <<< (w - 1);
          case ($urandom_range(7))
            0:       v = lim - 1;
            1:       v = -lim;
            2:       v = lim;
            3:       v = -lim - 1;
            default: v = $signed(raw << (64 - w)) >>> (64 - w);
          endcase
        end
        send_value(v, 4'd0, 72'h0);
      end
      drain_codes();
    end

    // Let any stray byte show up before the verdict.
    rx_stall_pct = 0;
    repeat (16) @(posedge clk_i);

    $display("Encoded %0d values into %0d checked bytes under four idling phases.",
             values_sent, bytes_checked);
    $display("Codes by length 1..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d; %0d mismatches.",
             codes_by_len[1], codes_by_len[2], codes_by_len[3], codes_by_len[4],
             codes_by_len[5], codes_by_len[6], codes_by_len[7], codes_by_len[8],
             codes_by_len[9], mismatches);
    if (mismatches == 0 && code_bytes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: signed_prefix_varint_encoder_core.f
+incdir+sv
sv/spve_pkg.sv
sv/spve_front.sv
sv/spve_fifo.sv
sv/spve_back.sv
sv/signed_prefix_varint_encoder_core.sv
tb/sv/signed_prefix_varint_encoder_core_tb.sv
